FILE: hdl/rdba_pkg.sv
// ----------------------------------------------------------------------------
// rdba_pkg
// Shared types and constants of the rotated damage blit addresser: beat
// layouts, job entries passed from front to back, configuration and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rdba_pkg;

    // largest frame side accepted by the layout check
    localparam int C_MAX_DIM = 4096;

    // depth of the front-to-back job queue
    localparam int C_Q_DEPTH = 4;
    localparam int C_Q_AW    = $clog2(C_Q_DEPTH);

    // input op codes
    localparam logic OP_RECT  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // result kinds
    localparam logic KIND_CLIP  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_RECT = 2'd1;
    localparam logic [1:0] ST_NO_RECT  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEST_PITCH   = 2'd2;

    // register reset values
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd2170;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd60;
    localparam logic [15:0] RST_DEST_PITCH   = 16'd240;

    // input beat
    typedef struct packed {
        logic        op;
        logic [11:0] rect_x;
        logic [11:0] rect_y;
        logic [12:0] rect_width;
        logic [12:0] rect_height;
        logic [31:0] pixel;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [12:0] clip_x1;
        logic [12:0] clip_y1;
        logic [12:0] clip_x2;
        logic [12:0] clip_y2;
        logic [27:0] dest_offset;
        logic [25:0] src_offset;
        logic [31:0] pixel_out;
        logic        last;
    } t_out_item;

    // configuration seen by both halves
    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [15:0] dest_pitch;
    } t_cfg;

    // classified item waiting for address generation
    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [12:0] clip_x1;
        logic [12:0] clip_y1;
        logic [12:0] clip_x2;
        logic [12:0] clip_y2;
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] pixel;
        logic        last;
    } t_job;

endpackage

`default_nettype wire

FILE: hdl/rdba_front.sv
// ----------------------------------------------------------------------------
// rdba_front
// Holds the configuration registers and the raster walk state. Checks each
// rectangle, steps through the armed rectangle per pixel and emits one job.
// ----------------------------------------------------------------------------
`default_nettype none

module rdba_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input beat and queue room
    input  wire                  i_take,
    input  rdba_pkg::t_in_item   i_item,
    // configuration write port
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [15:0]          i_cfg_data,
    // outputs
    output rdba_pkg::t_job       o_job,
    output rdba_pkg::t_cfg       o_cfg
);

    rdba_pkg::t_cfg r_cfg;
    logic [11:0] r_cur_col, n_cur_col;
    logic [11:0] r_cur_row, n_cur_row;
    logic [11:0] r_left_col, n_left_col;
    logic [12:0] r_right_end, n_right_end;
    logic [12:0] r_bottom_end, n_bottom_end;
    logic        r_armed, n_armed;

    logic        layout_ok;
    logic        rect_ok;
    logic [12:0] x_ext;
    logic [12:0] y_ext;
    logic [12:0] x_plus_w;
    logic [12:0] y_plus_h;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic        wrap;
    logic        done;
    logic        cfg_hit;

    // configuration registers; any known write drops the armed rectangle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= rdba_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height <= rdba_pkg::RST_FRAME_HEIGHT;
            r_cfg.dest_pitch   <= rdba_pkg::RST_DEST_PITCH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rdba_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[12:0];
                rdba_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[12:0];
                rdba_pkg::REG_DEST_PITCH:   r_cfg.dest_pitch   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // write to a register that exists
    assign cfg_hit = i_cfg_we && (i_cfg_index == rdba_pkg::REG_FRAME_WIDTH
        || i_cfg_index == rdba_pkg::REG_FRAME_HEIGHT
        || i_cfg_index == rdba_pkg::REG_DEST_PITCH);

    // rectangle and layout checks
    always_comb begin
        x_ext    = {1'b0, i_item.rect_x};
        y_ext    = {1'b0, i_item.rect_y};
        x_plus_w = x_ext + i_item.rect_width;
        y_plus_h = y_ext + i_item.rect_height;
        layout_ok = (r_cfg.frame_width != '0) && (r_cfg.frame_height != '0)
            && (32'(r_cfg.frame_width) <= 32'(rdba_pkg::C_MAX_DIM))
            && (32'(r_cfg.frame_height) <= 32'(rdba_pkg::C_MAX_DIM))
            && (r_cfg.dest_pitch >= {1'b0, r_cfg.frame_height, 2'b00});
        rect_ok = (i_item.rect_width != '0) && (i_item.rect_height != '0)
            && (x_ext < r_cfg.frame_width) && (y_ext < r_cfg.frame_height)
            && (i_item.rect_width <= r_cfg.frame_width - x_ext)
            && (i_item.rect_height <= r_cfg.frame_height - y_ext);
    end

    // raster step of the armed rectangle
    always_comb begin
        col_inc = {1'b0, r_cur_col} + 13'd1;
        row_inc = {1'b0, r_cur_row} + 13'd1;
        wrap    = col_inc >= r_right_end;
        done    = wrap && (row_inc >= r_bottom_end);
    end

    // job build and next walk state
    always_comb begin
        o_job        = '0;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_left_col   = r_left_col;
        n_right_end  = r_right_end;
        n_bottom_end = r_bottom_end;
        n_armed      = r_armed;
        if (i_item.op == rdba_pkg::OP_RECT) begin
            o_job.kind = rdba_pkg::KIND_CLIP;
            n_armed    = 1'b0;
            if (layout_ok && rect_ok) begin
                o_job.status  = rdba_pkg::ST_OK;
                o_job.clip_x1 = r_cfg.frame_height - y_plus_h;
                o_job.clip_y1 = x_ext;
                o_job.clip_x2 = r_cfg.frame_height - y_ext;
                o_job.clip_y2 = x_plus_w;
                n_cur_col     = i_item.rect_x;
                n_cur_row     = i_item.rect_y;
                n_left_col    = i_item.rect_x;
                n_right_end   = x_plus_w;
                n_bottom_end  = y_plus_h;
                n_armed       = 1'b1;
            end else begin
                o_job.status = rdba_pkg::ST_BAD_RECT;
            end
        end else begin
            o_job.kind = rdba_pkg::KIND_PIXEL;
            if (!r_armed) begin
                o_job.status = rdba_pkg::ST_NO_RECT;
            end else begin
                o_job.status = rdba_pkg::ST_OK;
                o_job.col    = r_cur_col;
                o_job.row    = r_cur_row;
                o_job.pixel  = i_item.pixel;
                o_job.last   = done;
                if (wrap) begin
                    n_cur_col = r_left_col;
                    n_cur_row = row_inc[11:0];
                    if (done) begin
                        n_armed = 1'b0;
                    end
                end else begin
                    n_cur_col = col_inc[11:0];
                end
            end
        end
    end

    // walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_left_col   <= '0;
            r_right_end  <= '0;
            r_bottom_end <= '0;
            r_armed      <= 1'b0;
        end else begin
            if (i_take) begin
                r_cur_col    <= n_cur_col;
                r_cur_row    <= n_cur_row;
                r_left_col   <= n_left_col;
                r_right_end  <= n_right_end;
                r_bottom_end <= n_bottom_end;
            end
            if (cfg_hit) begin
                r_armed <= 1'b0;
            end else if (i_take) begin
                r_armed <= n_armed;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rdba_queue.sv
// ----------------------------------------------------------------------------
// rdba_queue
// Short job queue between front and back. Full when every slot is taken;
// push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rdba_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  rdba_pkg::t_job       i_job,
    input  wire                  i_pop,
    output rdba_pkg::t_job       o_job,
    output logic                 o_full,
    output logic                 o_empty
);

    localparam int AW = rdba_pkg::C_Q_AW;
    localparam int DEPTH = rdba_pkg::C_Q_DEPTH;

    rdba_pkg::t_job r_slot [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rdba_back.sv
// ----------------------------------------------------------------------------
// rdba_back
// Address generation: a multiply stage forms col * pitch and row * width,
// then the output stage adds the row and column terms into byte offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module rdba_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  rdba_pkg::t_cfg       i_cfg,
    // queue side
    input  wire                  i_q_valid,
    input  rdba_pkg::t_job       i_q_job,
    output logic                 o_q_pop,
    // result beat
    output logic                 o_valid,
    input  wire                  i_stall,
    output rdba_pkg::t_out_item  o_result
);

    logic           r_s1_valid;
    rdba_pkg::t_job r_s1_job;
    logic [27:0]    r_s1_dst_prod;
    logic [23:0]    r_s1_src_prod;
    logic [25:0]    r_s1_row_term;
    logic           r_out_valid;
    rdba_pkg::t_out_item r_out;
    rdba_pkg::t_out_item n_out;

    logic out_free;
    logic s1_adv;
    logic s1_free;
    logic [25:0] src_prod_ext;

    // elastic flow control
    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || s1_adv;
    assign o_q_pop  = i_q_valid && s1_free;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_job      <= i_q_job;
            r_s1_dst_prod <= 28'(i_q_job.col) * 28'(i_cfg.dest_pitch);
            r_s1_src_prod <= 24'(i_q_job.row) * 24'(i_cfg.frame_width);
            r_s1_row_term <= 26'(i_cfg.frame_height) - 26'd1 - 26'(i_q_job.row);
        end
    end

    // offset sums; only good pixel beats carry offsets
    always_comb begin
        src_prod_ext        = {r_s1_src_prod, 2'b00};
        n_out               = '0;
        n_out.kind          = r_s1_job.kind;
        n_out.status        = r_s1_job.status;
        n_out.clip_x1       = r_s1_job.clip_x1;
        n_out.clip_y1       = r_s1_job.clip_y1;
        n_out.clip_x2       = r_s1_job.clip_x2;
        n_out.clip_y2       = r_s1_job.clip_y2;
        n_out.pixel_out     = r_s1_job.pixel;
        n_out.last          = r_s1_job.last;
        if (r_s1_job.kind == rdba_pkg::KIND_PIXEL && r_s1_job.status == rdba_pkg::ST_OK) begin
            n_out.dest_offset = r_s1_dst_prod + {r_s1_row_term, 2'b00};
            n_out.src_offset  = src_prod_ext + {12'd0, r_s1_job.col, 2'b00};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_q_pop;
            end
            if (out_free) begin
                r_out_valid <= s1_adv;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

FILE: hdl/rotated_damage_blit_addresser.sv
// An accepted beat goes through the job queue, multiply stage and output register.
// Throughput: one beat per cycle, rectangles and pixels alike, while the queue is not
// full; the front walk register and the multiply stage each take one beat per cycle.
// A four-entry job queue lets the front keep taking beats while results stall.
// Reset (synchronous, active low) restores the register defaults and disarms.
// ----------------------------------------------------------------------------
// rotated_damage_blit_addresser
// Top level: front classifier, job queue and address back end for a
// 90-degree rotated copy of damaged rectangles of a 32-bit pixel frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_damage_blit_addresser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_valid,
    output logic                 o_stall,
    input  rdba_pkg::t_in_item   i_item,
    // output channel
    output logic                 o_valid,
    input  wire                  i_stall,
    output rdba_pkg::t_out_item  o_result,
    // configuration
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [15:0]          i_cfg_data
);

    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           take;
    rdba_pkg::t_job front_job;
    rdba_pkg::t_job q_job;
    rdba_pkg::t_cfg cfg;

    assign o_stall = q_full;
    assign take    = i_valid && !q_full;

    rdba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job       (front_job),
        .o_cfg       (cfg)
    );

    rdba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rdba_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (!q_empty),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

FILE: hdl/rdba_checker.sv
// ----------------------------------------------------------------------------
// rdba_checker
// Port-level checks of the rotated damage blit addresser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rdba_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  o_valid,
    input  wire                  i_stall,
    input  rdba_pkg::t_out_item  o_result
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("result beat changed while stalled");

    // reset empties the output stage
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // last only on a good pixel beat
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |->
        (o_result.kind == rdba_pkg::KIND_PIXEL && o_result.status == rdba_pkg::ST_OK))
        else $error("last on a beat that is not a good pixel");

    // rejected rectangle carries no clip
    a_bad_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.kind == rdba_pkg::KIND_CLIP && o_result.status != rdba_pkg::ST_OK)
        |-> (o_result.clip_x1 == '0 && o_result.clip_y1 == '0
            && o_result.clip_x2 == '0 && o_result.clip_y2 == '0))
        else $error("clip fields on a rejected rectangle");

    // status code stays in its range and matches the kind
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status == rdba_pkg::ST_OK
            || (o_result.status == rdba_pkg::ST_BAD_RECT && o_result.kind == rdba_pkg::KIND_CLIP)
            || (o_result.status == rdba_pkg::ST_NO_RECT && o_result.kind == rdba_pkg::KIND_PIXEL)))
        else $error("status code does not fit the result kind");

endmodule

bind rotated_damage_blit_addresser rdba_checker u_rdba_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);

`default_nettype wire
